[hdl/pfam_pkg.sv]
// Shared types, constants and a helper function of the page frame allocator and mapper.
`default_nettype none

package pfam_pkg;

    localparam int FRAMES_DEF      = 32;
    localparam int DIRECTORIES_DEF = 4;

    localparam int FRAME_SHIFT = 22;
    localparam int PAGE_W      = 10;
    localparam int PAGES       = 1024;
    localparam int FRAME_W     = 10;
    localparam int COUNT_W     = 11;
    localparam int FREE_W      = 6;
    localparam int AMOUNT_W    = 32;
    localparam int WORD_W      = 32;
    localparam int BIT_W       = 5;

    localparam int ENTRY_W      = 14;
    localparam int FRAME_POS    = 4;
    localparam int FLAG_PRESENT = 0;
    localparam int FLAG_USER    = 2;
    localparam logic [FRAME_POS-1:0] ENTRY_FLAGS = 4'hF;

    typedef enum logic [1:0] {
        FUNC_CHECK = 2'd0,
        FUNC_ALLOC = 2'd1,
        FUNC_FREE  = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef struct packed {
        logic [1:0]          func;
        logic [1:0]          directory;
        logic [PAGE_W-1:0]   page_number;
        logic [AMOUNT_W-1:0] amount;
    } t_in_word;

    typedef struct packed {
        logic               ok;
        logic [FRAME_W-1:0] frame;
        logic [FREE_W-1:0]  free_frames;
    } t_out_word;

    typedef enum logic [2:0] {
        MAP_NOP        = 3'd0,
        MAP_CLEAR      = 3'd1,
        MAP_LOOK_ALLOC = 3'd2,
        MAP_LOOK_FREE  = 3'd3,
        MAP_ALLOC      = 3'd4,
        MAP_FREE       = 3'd5
    } t_map_op;

    typedef struct packed {
        t_map_op            op;
        logic [FRAME_W-1:0] idx;
    } t_map_cmd;

    typedef struct packed {
        logic               has_free;
        logic               used;
        logic [FRAME_W-1:0] frame;
        logic [COUNT_W-1:0] count;
    } t_map_stat;

    // Bits of the last map row that stand for frames beyond the frame count.
    function automatic logic [WORD_W-1:0] last_row_pad(input int frames);
        logic [WORD_W-1:0] pad;
        int                base;
        base = ((frames + WORD_W - 1) / WORD_W - 1) * WORD_W;
        for (int b = 0; b < WORD_W; b++) begin
            pad[b] = (base + b >= frames);
        end
        return pad;
    endfunction

endpackage

`default_nettype wire

[hdl/pfam_if.sv]
// Valid/ready channel interfaces for the request and response words.
`default_nettype none

interface pfam_in_if;
    logic               valid;
    logic               ready;
    pfam_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pfam_out_if;
    logic                valid;
    logic                ready;
    pfam_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/pfam_frame_map.sv]
// Frame used-bit map in a row memory with full-row summary bits and the free frame count.
`default_nettype none

module pfam_frame_map #(
    parameter int FRAMES = pfam_pkg::FRAMES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  pfam_pkg::t_map_cmd  i_cmd,
    output pfam_pkg::t_map_stat o_stat
);

    localparam int WORD_W = pfam_pkg::WORD_W;
    localparam int BIT_W  = pfam_pkg::BIT_W;
    localparam int ROWS   = (FRAMES + WORD_W - 1) / WORD_W;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W  = $clog2(FRAMES + 1);
    localparam logic [WORD_W-1:0] LAST_PAD = pfam_pkg::last_row_pad(FRAMES);
    localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [CNT_W-1:0]  FRAMES_C = CNT_W'(FRAMES);

    logic [WORD_W-1:0] r_map_mem [ROWS];
    logic [WORD_W-1:0] r_rd;
    logic [ROWS-1:0]   r_full;
    logic [CNT_W-1:0]  r_count;
    logic [ROW_W-1:0]  r_row;
    logic [BIT_W-1:0]  r_bit;

    logic [ROW_W-1:0]  free_row;
    logic [ROW_W-1:0]  look_row;
    logic              rd_en;
    logic [WORD_W-1:0] word_p;
    logic [BIT_W-1:0]  first_zero;
    logic              wr_en;
    logic [ROW_W-1:0]  wr_row;
    logic [WORD_W-1:0] wr_word;
    logic              n_full;

    always_comb begin
        free_row = '0;
        for (int i = ROWS - 1; i >= 0; i--) begin
            if (!r_full[i]) begin
                free_row = ROW_W'(i);
            end
        end
    end

    assign rd_en    = (i_cmd.op == pfam_pkg::MAP_LOOK_ALLOC) ||
                      (i_cmd.op == pfam_pkg::MAP_LOOK_FREE);
    assign look_row = (i_cmd.op == pfam_pkg::MAP_LOOK_FREE) ?
                      i_cmd.idx[BIT_W +: ROW_W] : free_row;

    assign word_p = r_rd | ((r_row == LAST_ROW) ? LAST_PAD : '0);

    always_comb begin
        first_zero = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!word_p[i]) begin
                first_zero = BIT_W'(i);
            end
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_row  = r_row;
        wr_word = r_rd;
        case (i_cmd.op)
            pfam_pkg::MAP_CLEAR: begin
                wr_en   = 1'b1;
                wr_row  = i_cmd.idx[ROW_W-1:0];
                wr_word = '0;
            end
            pfam_pkg::MAP_ALLOC: begin
                wr_en   = 1'b1;
                wr_word = r_rd | (WORD_W'(1) << first_zero);
            end
            pfam_pkg::MAP_FREE: begin
                wr_en   = 1'b1;
                wr_word = r_rd & ~(WORD_W'(1) << r_bit);
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign n_full = &(wr_word | ((wr_row == LAST_ROW) ? LAST_PAD : '0));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_map_mem[wr_row] <= wr_word;
        end
        if (rd_en) begin
            r_rd  <= r_map_mem[look_row];
            r_row <= look_row;
            r_bit <= i_cmd.idx[BIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full  <= '0;
            r_count <= FRAMES_C;
        end else begin
            if (wr_en) begin
                r_full[wr_row] <= n_full;
            end
            if (i_cmd.op == pfam_pkg::MAP_ALLOC && r_count != '0) begin
                r_count <= r_count - CNT_W'(1);
            end else if (i_cmd.op == pfam_pkg::MAP_FREE && r_rd[r_bit] &&
                         r_count < FRAMES_C) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    assign o_stat.has_free = ~&r_full;
    assign o_stat.used     = r_rd[r_bit];
    assign o_stat.frame    = pfam_pkg::FRAME_W'({r_row, first_zero});
    assign o_stat.count    = pfam_pkg::COUNT_W'(r_count);

endmodule

`default_nettype wire

[hdl/page_frame_allocator_mapper.sv]
// Page frame allocator and mapper: request sequencer, directory entry memory and response register.
//
// Usage: requests arrive as words on i_in (valid/ready) and each one yields exactly one
// response word on o_out (valid/ready). A capacity check compares the frames needed for
// an amount with the free count, an allocate takes the lowest free frame and maps it into
// the addressed directory entry, and a free releases the frame of an entry and clears it.
// A check or an allocate loads the response register in the lookup state, a free in the later
// free state, because the frame map row can only be read once the entry is known.
// The block works on one request at a time, since the directory memory and the frame map
// memory are updated by read-modify-write.
// Reset: a clearing pass writes every directory entry to zero, one entry per cycle, and
// i_in.ready stays low during that time. All frames are free.
// Stall: a response waits in the output register while o_out.ready is low; the next
// request is still accepted and runs until its response is due, then it waits too.
`default_nettype none

module page_frame_allocator_mapper #(
    parameter int FRAMES      = pfam_pkg::FRAMES_DEF,
    parameter int DIRECTORIES = pfam_pkg::DIRECTORIES_DEF
) (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    pfam_in_if.sink     i_in,
    pfam_out_if.source  o_out
);

    localparam int DEPTH   = DIRECTORIES * pfam_pkg::PAGES;
    localparam int DIR_W   = (DIRECTORIES > 1) ? $clog2(DIRECTORIES) : 1;
    localparam int ADDR_W  = DIR_W + pfam_pkg::PAGE_W;
    localparam int ENTRY_W = pfam_pkg::ENTRY_W;
    localparam int COUNT_W = pfam_pkg::COUNT_W;
    localparam int FREE_W  = pfam_pkg::FREE_W;
    localparam int ROWS    = (FRAMES + pfam_pkg::WORD_W - 1) / pfam_pkg::WORD_W;
    localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W:0]    ROWS_A    = (ADDR_W + 1)'(ROWS);
    localparam logic [6:0]         DIRS_L    = 7'(DIRECTORIES);
    localparam logic [COUNT_W-1:0] FRAMES_L  = COUNT_W'(FRAMES);
    localparam logic [32:0]        ROUND_UP  = 33'((64'd1 << pfam_pkg::FRAME_SHIFT) - 64'd1);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_LOOK  = 4'b0100,
        ST_FREE  = 4'b1000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    pfam_pkg::t_in_word  r_req;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [ENTRY_W-1:0]  r_dir_mem [DEPTH];
    logic [ENTRY_W-1:0]  r_entry;
    logic                r_out_valid;
    logic                n_out_valid;
    pfam_pkg::t_out_word r_out;
    pfam_pkg::t_out_word n_res;

    pfam_pkg::t_map_cmd  map_cmd;
    pfam_pkg::t_map_stat map_stat;

    logic                            in_accept;
    logic                            emit_ok;
    logic                            emit;
    logic                            dir_rd_en;
    logic [ADDR_W-1:0]               dir_rd_addr;
    logic                            dir_wr_en;
    logic [ADDR_W-1:0]               dir_wr_addr;
    logic [ENTRY_W-1:0]              dir_wr_data;
    logic [ADDR_W-1:0]               req_addr;
    logic                            dir_ok;
    logic [32:0]                     need_sum;
    logic [COUNT_W-1:0]              need;
    logic [pfam_pkg::FRAME_W-1:0]    entry_frame;
    logic                            free_bad;
    logic [COUNT_W-1:0]              cnt;
    logic [COUNT_W-1:0]              cnt_dec;
    logic [COUNT_W-1:0]              cnt_inc;

    pfam_frame_map #(
        .FRAMES (FRAMES)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (map_cmd),
        .o_stat  (map_stat)
    );

    assign i_in.ready  = (r_state == ST_IDLE);
    assign in_accept   = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign emit_ok     = !r_out_valid || o_out.ready;

    assign dir_rd_addr = {DIR_W'(i_in.data.directory), i_in.data.page_number};
    assign req_addr    = {DIR_W'(r_req.directory), r_req.page_number};
    assign dir_ok      = {5'd0, r_req.directory} < DIRS_L;
    assign need_sum    = {1'b0, r_req.amount} + ROUND_UP;
    assign need        = need_sum[32:pfam_pkg::FRAME_SHIFT];
    assign entry_frame = r_entry[ENTRY_W-1:pfam_pkg::FRAME_POS];
    assign free_bad    = !r_entry[pfam_pkg::FLAG_PRESENT] || !r_entry[pfam_pkg::FLAG_USER] ||
                         ({1'b0, entry_frame} >= FRAMES_L);
    assign cnt         = map_stat.count;
    assign cnt_dec     = cnt - COUNT_W'(cnt != '0);
    assign cnt_inc     = cnt + COUNT_W'(map_stat.used && cnt < FRAMES_L);

    always_comb begin
        n_state     = r_state;
        map_cmd.op  = pfam_pkg::MAP_NOP;
        map_cmd.idx = '0;
        dir_rd_en   = 1'b0;
        dir_wr_en   = 1'b0;
        dir_wr_addr = req_addr;
        dir_wr_data = '0;
        emit        = 1'b0;
        n_res.ok          = 1'b0;
        n_res.frame       = '0;
        n_res.free_frames = cnt[FREE_W-1:0];
        case (r_state)
            ST_CLEAR: begin
                dir_wr_en   = 1'b1;
                dir_wr_addr = r_clr_addr;
                if ({1'b0, r_clr_addr} < ROWS_A) begin
                    map_cmd.op  = pfam_pkg::MAP_CLEAR;
                    map_cmd.idx = pfam_pkg::FRAME_W'(r_clr_addr);
                end
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in.valid) begin
                    dir_rd_en  = 1'b1;
                    map_cmd.op = pfam_pkg::MAP_LOOK_ALLOC;
                    n_state    = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (r_req.func == pfam_pkg::FUNC_CHECK) begin
                    if (emit_ok) begin
                        emit     = 1'b1;
                        n_res.ok = (cnt >= need);
                        n_state  = ST_IDLE;
                    end
                end else if (r_req.func == pfam_pkg::FUNC_NONE || !dir_ok) begin
                    if (emit_ok) begin
                        emit    = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else if (r_req.func == pfam_pkg::FUNC_ALLOC) begin
                    if (emit_ok) begin
                        emit    = 1'b1;
                        n_state = ST_IDLE;
                        if (map_stat.has_free) begin
                            map_cmd.op        = pfam_pkg::MAP_ALLOC;
                            dir_wr_en         = 1'b1;
                            dir_wr_data       = {map_stat.frame, pfam_pkg::ENTRY_FLAGS};
                            n_res.ok          = 1'b1;
                            n_res.frame       = map_stat.frame;
                            n_res.free_frames = cnt_dec[FREE_W-1:0];
                        end
                    end
                end else if (free_bad) begin
                    if (emit_ok) begin
                        emit    = 1'b1;
                        n_state = ST_IDLE;
                    end
                end else begin
                    map_cmd.op  = pfam_pkg::MAP_LOOK_FREE;
                    map_cmd.idx = entry_frame;
                    n_state     = ST_FREE;
                end
            end
            ST_FREE: begin
                if (emit_ok) begin
                    map_cmd.op        = pfam_pkg::MAP_FREE;
                    dir_wr_en         = 1'b1;
                    emit              = 1'b1;
                    n_res.ok          = 1'b1;
                    n_res.frame       = entry_frame;
                    n_res.free_frames = cnt_inc[FREE_W-1:0];
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign n_out_valid = emit ? 1'b1 : (o_out.ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (dir_wr_en) begin
            r_dir_mem[dir_wr_addr] <= dir_wr_data;
        end
        if (dir_rd_en) begin
            r_entry <= r_dir_mem[dir_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req <= i_in.data;
        end
        if (emit) begin
            r_out <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_word_during_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CLEAR |-> !r_out_valid)
        else $error("response word present during the clearing pass");

    a_accept_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == ST_LOOK)
        else $error("accepted request did not start its lookup");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_CLEAR |-> cnt <= FRAMES_L)
        else $error("free frame count exceeds the frame count");

    a_frame_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ({1'b0, r_out.frame} < FRAMES_L))
        else $error("response word names a frame beyond the frame count");

    a_single_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_state == ST_IDLE)
        else $error("request produced a response word but did not finish");
`endif

endmodule

`default_nettype wire
